// ===== design/circle_rasterizer_macros.svh =====
// ---------------------------------------------------------------------------
// circle rasterizer assertion macros
// shared concurrent assertion forms used by the top level
// ---------------------------------------------------------------------------
`ifndef CIRCLE_RASTERIZER_MACROS_SVH
`define CIRCLE_RASTERIZER_MACROS_SVH

// same-cycle implication under reset
`define CCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circle rasterizer assertion failed");

// next-cycle implication under reset
`define CCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circle rasterizer assertion failed");

`endif

// ===== design/ccr_pkg.sv =====
// ---------------------------------------------------------------------------
// ccr_pkg
// types, codes and defaults shared by the circle rasterizer modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccr_pkg;

    localparam int MAX_SIDE_DEF  = 256;
    localparam int FRAC_BITS_DEF = 8;

    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_DRAW  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REJECT  = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

    localparam logic [7:0] KIND_OUTLINE = 8'h63;
    localparam logic [7:0] KIND_FILLED  = 8'h43;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

    localparam logic [8:0] WIDTH_RST  = 9'd256;
    localparam logic [8:0] HEIGHT_RST = 9'd256;
    localparam logic [7:0] BG_RST     = 8'd32;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         circle_kind;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic signed [23:0] circle_radius;
        logic [7:0]         fill_char;
        logic [7:0]         read_col;
        logic [7:0]         read_row;
    } cmd_t;

    typedef struct packed {
        logic [7:0] pixel_char;
        logic [1:0] status;
    } rsp_t;

endpackage

// ===== design/ccr_canvas.sv =====
// ---------------------------------------------------------------------------
// ccr_canvas
// character store, one write port and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_canvas #(
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/ccr_square.sv =====
// ---------------------------------------------------------------------------
// ccr_square
// shared squaring unit with registered product
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_square #(
    parameter int OP_W = 25
) (
    input  logic                     clk,
    input  logic signed [OP_W-1:0]   a,
    output logic signed [2*OP_W-1:0] sq
);

    always_ff @(posedge clk)
    begin
        sq <= a * a;
    end

endmodule

// ===== design/ccr_engine.sv =====
// ---------------------------------------------------------------------------
// ccr_engine
// command sequencer: clear sweep, circle scan and pixel read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_engine #(
    parameter int MAX_SIDE  = ccr_pkg::MAX_SIDE_DEF,
    parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF,
    localparam int IDX_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ccr_pkg::cmd_t     cmd,
    input  logic [SIDE_W-1:0] eff_w,
    input  logic [SIDE_W-1:0] eff_h,
    input  logic [7:0]        bg,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_take,
    output ccr_pkg::rsp_t     result
);

    localparam int ADDR_W  = 2 * IDX_W;
    localparam int OP_W    = 25;
    localparam int COORD_W = ((IDX_W + FRAC_BITS > 23) ? IDX_W + FRAC_BITS : 23) + 2;
    localparam int AW      = 2 * COORD_W + 2;
    localparam int CMP_W   = (SIDE_W > 8) ? SIDE_W : 8;

    localparam logic signed [OP_W-1:0] ONE_OP  = OP_W'(64'd1 << FRAC_BITS);
    localparam logic signed [AW-1:0]   ONE_SQ  = AW'(1) << (2 * FRAC_BITS);
    localparam logic signed [AW-1:0]   STEP_SQ = AW'(1) << (2 * FRAC_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_R,
        ST_SQ_IN,
        ST_SQ_CX,
        ST_SQ_CY,
        ST_SQ_END,
        ST_SCAN,
        ST_CLEAR,
        ST_RD_REQ,
        ST_RD_DATA,
        ST_DONE
    } state_t;

    state_t                   state_reg;
    logic signed [23:0]       cx_reg;
    logic signed [23:0]       cy_reg;
    logic signed [23:0]       r_reg;
    logic                     outline_reg;
    logic                     rim_all_reg;
    logic [7:0]               fill_reg;
    logic [IDX_W-1:0]         rcol_reg;
    logic [IDX_W-1:0]         rrow_reg;
    logic [IDX_W-1:0]         col_reg;
    logic [IDX_W-1:0]         row_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic signed [AW-1:0]     r2_reg;
    logic signed [AW-1:0]     in2_reg;
    logic signed [AW-1:0]     cx2_reg;
    logic signed [AW-1:0]     s_reg;
    logic signed [AW-1:0]     base_reg;
    logic signed [AW-1:0]     tx_reg;
    logic signed [AW-1:0]     tx0_reg;
    logic signed [AW-1:0]     ty_reg;
    ccr_pkg::rsp_t            result_reg;

    logic signed [OP_W-1:0]   sq_op;
    logic signed [2*OP_W-1:0] sq_out;
    logic                     hit;
    logic                     col_last;
    logic                     row_last;
    logic                     kind_ok;
    logic                     kind_outline;
    logic [CMP_W-1:0]         rd_col_ext;
    logic [CMP_W-1:0]         rd_row_ext;
    logic                     rd_outside;
    logic signed [AW-1:0]     base_step;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [7:0]               mem_wdata;
    logic                     mem_re;
    logic [7:0]               mem_rdata;

    ccr_square #(
        .OP_W (OP_W)
    ) u_square (
        .clk (clk),
        .a   (sq_op),
        .sq  (sq_out)
    );

    ccr_canvas #(
        .ADDR_W (ADDR_W)
    ) u_canvas (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr ({rrow_reg, rcol_reg}),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_SQ_R:  sq_op = OP_W'(r_reg);
            ST_SQ_IN: sq_op = OP_W'(r_reg) - ONE_OP;
            ST_SQ_CX: sq_op = OP_W'(cx_reg);
            ST_SQ_CY: sq_op = OP_W'(cy_reg);
            default:  sq_op = '0;
        endcase
    end

    assign hit       = (s_reg <= r2_reg) && (!outline_reg || rim_all_reg || (s_reg > in2_reg));
    assign col_last  = (SIDE_W'(col_reg) + SIDE_W'(1)) == eff_w;
    assign row_last  = (SIDE_W'(row_reg) + SIDE_W'(1)) == eff_h;
    assign base_step = base_reg + ty_reg;

    assign kind_outline = cmd.circle_kind == ccr_pkg::KIND_OUTLINE;
    assign kind_ok      = kind_outline || (cmd.circle_kind == ccr_pkg::KIND_FILLED);
    assign rd_col_ext   = CMP_W'(cmd.read_col);
    assign rd_row_ext   = CMP_W'(cmd.read_row);
    assign rd_outside   = (rd_col_ext >= CMP_W'(eff_w)) || (rd_row_ext >= CMP_W'(eff_h));

    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_SCAN) && hit);
    assign mem_waddr = (state_reg == ST_CLEAR) ? addr_reg : {row_reg, col_reg};
    assign mem_wdata = (state_reg == ST_CLEAR) ? bg : fill_reg;
    assign mem_re    = state_reg == ST_RD_REQ;

    assign idle      = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cx_reg      <= '0;
            cy_reg      <= '0;
            r_reg       <= '0;
            outline_reg <= 1'b0;
            rim_all_reg <= 1'b0;
            fill_reg    <= '0;
            rcol_reg    <= '0;
            rrow_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            addr_reg    <= '0;
            r2_reg      <= '0;
            in2_reg     <= '0;
            cx2_reg     <= '0;
            s_reg       <= '0;
            base_reg    <= '0;
            tx_reg      <= '0;
            tx0_reg     <= '0;
            ty_reg      <= '0;
            result_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        result_reg.pixel_char <= 8'd0;
                        cx_reg      <= cmd.center_x;
                        cy_reg      <= cmd.center_y;
                        r_reg       <= cmd.circle_radius;
                        outline_reg <= kind_outline;
                        rim_all_reg <= OP_W'(cmd.circle_radius) < ONE_OP;
                        fill_reg    <= cmd.fill_char;
                        rcol_reg    <= rd_col_ext[IDX_W-1:0];
                        rrow_reg    <= rd_row_ext[IDX_W-1:0];
                        col_reg     <= '0;
                        row_reg     <= '0;
                        addr_reg    <= '0;
                        tx0_reg     <= ONE_SQ - (AW'(cmd.center_x) <<< (FRAC_BITS + 1));
                        tx_reg      <= ONE_SQ - (AW'(cmd.center_x) <<< (FRAC_BITS + 1));
                        ty_reg      <= ONE_SQ - (AW'(cmd.center_y) <<< (FRAC_BITS + 1));
                        unique case (cmd.func)
                            ccr_pkg::FUNC_CLEAR:
                            begin
                                result_reg.status <= ccr_pkg::STATUS_OK;
                                state_reg         <= ST_CLEAR;
                            end
                            ccr_pkg::FUNC_DRAW:
                            begin
                                if ((cmd.circle_radius <= 24'sd0) || !kind_ok)
                                begin
                                    result_reg.status <= ccr_pkg::STATUS_REJECT;
                                    state_reg         <= ST_DONE;
                                end
                                else if ((eff_w == '0) || (eff_h == '0))
                                begin
                                    result_reg.status <= ccr_pkg::STATUS_OK;
                                    state_reg         <= ST_DONE;
                                end
                                else
                                begin
                                    result_reg.status <= ccr_pkg::STATUS_OK;
                                    state_reg         <= ST_SQ_R;
                                end
                            end
                            ccr_pkg::FUNC_READ:
                            begin
                                if (rd_outside)
                                begin
                                    result_reg.status <= ccr_pkg::STATUS_OUTSIDE;
                                    state_reg         <= ST_DONE;
                                end
                                else
                                begin
                                    result_reg.status <= ccr_pkg::STATUS_OK;
                                    state_reg         <= ST_RD_REQ;
                                end
                            end
                            default:
                            begin
                                result_reg.status <= ccr_pkg::STATUS_OK;
                                state_reg         <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SQ_R:
                begin
                    state_reg <= ST_SQ_IN;
                end
                ST_SQ_IN:
                begin
                    r2_reg    <= AW'(sq_out);
                    state_reg <= ST_SQ_CX;
                end
                ST_SQ_CX:
                begin
                    in2_reg   <= AW'(sq_out);
                    state_reg <= ST_SQ_CY;
                end
                ST_SQ_CY:
                begin
                    cx2_reg   <= AW'(sq_out);
                    state_reg <= ST_SQ_END;
                end
                ST_SQ_END:
                begin
                    s_reg     <= cx2_reg + AW'(sq_out);
                    base_reg  <= cx2_reg + AW'(sq_out);
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (col_last)
                    begin
                        col_reg <= '0;
                        if (row_last)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            // step to the next row: base holds cx^2 + dy^2
                            row_reg  <= row_reg + IDX_W'(1);
                            base_reg <= base_step;
                            s_reg    <= base_step;
                            ty_reg   <= ty_reg + STEP_SQ;
                            tx_reg   <= tx0_reg;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + IDX_W'(1);
                        s_reg   <= s_reg + tx_reg;
                        tx_reg  <= tx_reg + STEP_SQ;
                    end
                end
                ST_CLEAR:
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (addr_reg == '1)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_RD_REQ:
                begin
                    state_reg <= ST_RD_DATA;
                end
                ST_RD_DATA:
                begin
                    result_reg.pixel_char <= mem_rdata;
                    state_reg             <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/circle_rasterizer.sv =====
// ---------------------------------------------------------------------------
// circle_rasterizer
// character canvas with clear, circle draw and pixel read commands
// ---------------------------------------------------------------------------
// usage
//   cmd channel (cmd_valid / cmd_ready / cmd) takes one command per transaction:
//   clear, draw circle or read pixel. rsp channel (rsp_valid / rsp_ready / rsp)
//   returns exactly one result per command, in order.
//   configuration: wr_en writes wr_data to register wr_index (0 width,
//   1 height, 2 background char) in the same cycle; write only while idle.
//   from accept to rsp_valid: a read requests the canvas and registers the
//   data; a rejected or empty draw goes straight to the result; clear fills
//   all 4^ceil(log2 MAX_SIDE) cells; draw scans width * height pixels, one
//   pixel per cycle via incremental distance adders and compares, after four
//   squaring steps on the shared multiplier. cmd_ready rises with rsp_valid.
//   one command is in flight at a time; cmd_ready is high only while the
//   sequencer is idle. a finished result sits in the output register, so the
//   next command is taken while the receiver stalls; a second result waits
//   in the sequencer until the output register drains.
//   reset clears control state and sets width and height to 256 and the
//   background char to space; canvas contents are undefined until cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circle_rasterizer_macros.svh"

module circle_rasterizer #(
    parameter int MAX_SIDE  = ccr_pkg::MAX_SIDE_DEF,
    parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  ccr_pkg::cmd_t                 cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output ccr_pkg::rsp_t                 rsp,
    input  logic                          wr_en,
    input  logic [ccr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [ccr_pkg::CFG_W-1:0]     wr_data
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int EW     = (SIDE_W > 9) ? SIDE_W : 9;
    localparam logic [EW-1:0] MAX_EXT = EW'(MAX_SIDE);

    logic [8:0]        width_reg;
    logic [8:0]        height_reg;
    logic [7:0]        bg_reg;
    logic              rsp_valid_reg;
    ccr_pkg::rsp_t     rsp_reg;

    logic [EW-1:0]     w_ext;
    logic [EW-1:0]     h_ext;
    logic [SIDE_W-1:0] eff_w;
    logic [SIDE_W-1:0] eff_h;
    logic              eng_idle;
    logic              eng_res_valid;
    logic              res_take;
    ccr_pkg::rsp_t     eng_result;
    logic              start;

    assign w_ext = EW'(width_reg);
    assign h_ext = EW'(height_reg);
    assign eff_w = (w_ext > MAX_EXT) ? MAX_EXT[SIDE_W-1:0] : w_ext[SIDE_W-1:0];
    assign eff_h = (h_ext > MAX_EXT) ? MAX_EXT[SIDE_W-1:0] : h_ext[SIDE_W-1:0];

    assign cmd_ready = eng_idle;
    assign start     = cmd_valid && cmd_ready;
    assign res_take  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ccr_engine #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .bg        (bg_reg),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res_take  (res_take),
        .result    (eng_result)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ccr_pkg::WIDTH_RST;
            height_reg <= ccr_pkg::HEIGHT_RST;
            bg_reg     <= ccr_pkg::BG_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ccr_pkg::REG_WIDTH:  width_reg  <= wr_data;
                ccr_pkg::REG_HEIGHT: height_reg <= wr_data;
                ccr_pkg::REG_BG:     bg_reg     <= wr_data[7:0];
                default:             bg_reg     <= bg_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= eng_res_valid;
            if (eng_res_valid)
            begin
                rsp_reg <= eng_result;
            end
        end
    end

    `CCR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start, !cmd_ready)
    `CCR_ASSERT_IMPL(a_status_code, clk, rst_n, rsp_valid, rsp.status != 2'd3)
    `CCR_ASSERT_IMPL(a_char_zero_on_error, clk, rst_n, rsp_valid && (rsp.status != ccr_pkg::STATUS_OK), rsp.pixel_char == 8'd0)
    `CCR_ASSERT_NEXT(a_result_held, clk, rst_n, eng_res_valid && !res_take, eng_res_valid && $stable(eng_result))

endmodule
